// ===== rtl/servo_pulse_ramp_controller_unit_assert.svh =====
// Assertion macros for the servo pulse ramp controller.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef SERVO_PULSE_RAMP_CONTROLLER_UNIT_ASSERT_SVH
`define SERVO_PULSE_RAMP_CONTROLLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define SPR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spr assertion failed");

// Next-cycle implication, checked out of reset
`define SPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spr assertion failed");

`else

`define SPR_ASSERT_NOW(lbl, ante, cons)
`define SPR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/spr_pkg.sv =====
// Shared types, codes and helpers for the servo pulse ramp controller.
// No dependencies; used by the divider and the top level.
package spr_pkg;

    localparam int PULSE_W   = 16;
    localparam int DUR_W     = 16;
    localparam int ACT_W     = 3;
    localparam int CHAN_W    = 2;
    localparam int MASK_W    = 4;
    localparam int REG_IDX_W = 2;

    typedef logic [PULSE_W-1:0] pulse_t;
    typedef logic [ACT_W-1:0]   act_t;

    // Action codes
    localparam act_t ACT_TICK      = 3'd0;
    localparam act_t ACT_SET_NOW   = 3'd1;
    localparam act_t ACT_SET_TIMED = 3'd2;
    localparam act_t ACT_STOP_ALL  = 3'd3;
    localparam act_t ACT_RESET_ALL = 3'd4;
    localparam act_t ACT_QUERY     = 3'd5;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_MIN_PULSE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_PULSE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MID_PULSE = 2'd2;

    // Register reset values
    localparam pulse_t MIN_PULSE_RST = 16'd500;
    localparam pulse_t MAX_PULSE_RST = 16'd2500;
    localparam pulse_t MID_PULSE_RST = 16'd1500;

    // Clamp to max first, then to min, so min wins when limits cross
    function automatic pulse_t clamp_pulse(pulse_t v, pulse_t lo, pulse_t hi);
        pulse_t r;
        r = (v > hi) ? hi : v;
        r = (r < lo) ? lo : r;
        return r;
    endfunction

endpackage

// ===== rtl/spr_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on spr_pkg for the divisor width.
module spr_div #(
    parameter int DIVIDEND_W = 42
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DIVIDEND_W-1:0]     dividend,
    input  logic [spr_pkg::DUR_W-1:0] divisor,
    output logic                      done,
    output logic [DIVIDEND_W-1:0]     quotient
);
    import spr_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DUR_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic [DUR_W:0]        rem_shift;
    logic [DUR_W:0]        rem_sub;
    logic                  fits;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits      = rem_shift >= {1'b0, divisor};
    assign rem_sub   = rem_shift - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg <= dividend;
                rem_reg <= '0;
                cnt_reg <= CNT_W'(DIVIDEND_W);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
                rem_reg <= fits ? rem_sub[DUR_W-1:0] : rem_shift[DUR_W-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/servo_pulse_ramp_controller_unit.sv =====
// Servo pulse ramp controller: per-channel linear ramps under a small sequencer.
// A tick visits every channel in turn; timed set and reset-all ramps wait on the divider,
// once per channel for reset-all; every flagged channel then gets its own compare write.
// Throughput: one transaction at a time; busy drops as the last result is strobed; no stall.
// Reset (rst_n low, async): every channel at mid width, not ramping; limits at defaults.
`include "servo_pulse_ramp_controller_unit_assert.svh"
module servo_pulse_ramp_controller_unit #(
    parameter int CHANNELS  = 4,
    parameter int FRAC_BITS = 16,
    parameter int TICK_MS   = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [spr_pkg::ACT_W-1:0]     action,
    input  logic [spr_pkg::CHAN_W-1:0]    channel,
    input  logic [spr_pkg::PULSE_W-1:0]   pulse,
    input  logic [spr_pkg::DUR_W-1:0]     duration_ms,
    input  logic                          wr_en,
    input  logic [spr_pkg::REG_IDX_W-1:0] wr_index,
    input  logic [spr_pkg::PULSE_W-1:0]   wr_data,
    output logic                          strobe,
    output logic [spr_pkg::CHAN_W-1:0]    out_channel,
    output logic [spr_pkg::PULSE_W-1:0]   out_pulse,
    output logic                          write_valid,
    output logic [spr_pkg::MASK_W-1:0]    done_mask,
    output logic                          all_done,
    output logic                          last
);
    import spr_pkg::*;

    localparam int POS_W  = PULSE_W + FRAC_BITS;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TICK_W = $clog2(TICK_MS + 1);
    localparam int DIV_W  = POS_W + TICK_W;
    localparam logic [CH_W-1:0]  LAST_CH = CH_W'(CHANNELS - 1);
    localparam logic [DIV_W-1:0] TICK_K  = DIV_W'(TICK_MS);
    localparam logic [DUR_W-1:0] TICK_D  = DUR_W'(TICK_MS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_DIFF,
        S_TICK_STEP,
        S_TIMED_DIFF,
        S_DIV_START,
        S_DIV_WAIT,
        S_FINISH,
        S_EMIT,
        S_STATUS
    } state_t;

    state_t               state_reg;
    act_t                 action_reg;
    logic [CHAN_W-1:0]    chan_reg;
    logic                 chan_ok_reg;
    pulse_t               pulse_reg;
    logic [DUR_W-1:0]     dur_reg;
    logic [CH_W-1:0]      idx_reg;
    logic [CHANNELS-1:0]  pend_reg;
    logic [POS_W-1:0]     mag_reg;
    logic                 neg_reg;
    pulse_t               min_reg;
    pulse_t               max_reg;
    pulse_t               mid_reg;

    pulse_t               target_reg  [CHANNELS];
    logic [POS_W-1:0]     pos_reg     [CHANNELS];
    logic [POS_W-1:0]     inc_mag_reg [CHANNELS];
    logic [CHANNELS-1:0]  inc_neg_reg;

    logic                 strobe_reg;
    logic [CHAN_W-1:0]    out_channel_reg;
    pulse_t               out_pulse_reg;
    logic                 write_valid_reg;
    logic [MASK_W-1:0]    done_mask_reg;
    logic                 all_done_reg;
    logic                 last_reg;

    logic [CHANNELS-1:0]  moving;
    logic [MASK_W-1:0]    mask_now;
    logic [POS_W-1:0]     pos_rd;
    pulse_t               tgt_rd;
    logic [POS_W-1:0]     inc_rd;
    pulse_t               timed_pulse;
    pulse_t               setnow_pulse;
    pulse_t               diff_tgt;
    logic [POS_W:0]       diff;
    logic [POS_W:0]       diff_neg;
    logic [POS_W-1:0]     mag_next;
    logic                 snap;
    logic [POS_W-1:0]     pos_step_next;
    pulse_t               shown;
    logic [POS_W-1:0]     quo_fix;
    logic                 last_ch;
    logic [CHANNELS-1:0]  pend_rest;
    logic [CH_W-1:0]      in_ch;
    logic                 in_ok;
    logic                 dur_short;
    logic                 div_start;
    logic                 div_done;
    logic [DIV_W-1:0]     div_dividend;
    logic [DIV_W-1:0]     div_quotient;

    // Per-channel motion flags and the status mask
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_moving
        assign moving[g] = inc_mag_reg[g] != '0;
    end

    for (genvar m = 0; m < MASK_W; m++)
    begin : g_mask
        if (m < CHANNELS)
        begin : g_present
            assign mask_now[m] = ~moving[m];
        end
        else
        begin : g_absent
            assign mask_now[m] = 1'b1;
        end
    end

    // Read the addressed channel
    assign pos_rd = pos_reg[idx_reg];
    assign tgt_rd = target_reg[idx_reg];
    assign inc_rd = inc_mag_reg[idx_reg];

    assign timed_pulse  = clamp_pulse((action_reg == ACT_RESET_ALL) ? mid_reg : pulse_reg,
                                      min_reg, max_reg);
    assign setnow_pulse = clamp_pulse(pulse, min_reg, max_reg);

    // Shared subtractor: distance from current position to target
    assign diff_tgt = (state_reg == S_TIMED_DIFF) ? timed_pulse : tgt_rd;
    assign diff     = {1'b0, diff_tgt, {FRAC_BITS{1'b0}}} - {1'b0, pos_rd};
    assign diff_neg = -diff;
    assign mag_next = diff[POS_W] ? diff_neg[POS_W-1:0] : diff[POS_W-1:0];

    // Tick step: snap when within twice the increment, else advance
    assign snap          = {1'b0, mag_reg} <= {inc_rd, 1'b0};
    assign pos_step_next = inc_neg_reg[idx_reg] ? (pos_rd - inc_rd) : (pos_rd + inc_rd);

    assign shown = clamp_pulse(pos_rd[POS_W-1 -: PULSE_W], min_reg, max_reg);

    // Minimum step of one LSB toward a distinct target
    assign quo_fix = (div_quotient[POS_W-1:0] == '0 && mag_reg != '0)
                   ? POS_W'(1) : div_quotient[POS_W-1:0];

    assign last_ch   = idx_reg == LAST_CH;
    assign in_ch     = CH_W'(channel);
    assign in_ok     = int'(channel) < CHANNELS;
    assign dur_short = dur_reg < TICK_D;

    always_comb
    begin
        pend_rest          = pend_reg;
        pend_rest[idx_reg] = 1'b0;
    end

    // Serial divider for the ramp increment
    assign div_start    = state_reg == S_DIV_START;
    assign div_dividend = DIV_W'(mag_reg) * TICK_K;

    spr_div #(
        .DIVIDEND_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dur_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer, channel state, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            min_reg     <= MIN_PULSE_RST;
            max_reg     <= MAX_PULSE_RST;
            mid_reg     <= MID_PULSE_RST;
            idx_reg     <= '0;
            pend_reg    <= '0;
            inc_neg_reg <= '0;
            strobe_reg  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                target_reg[i]  <= MID_PULSE_RST;
                pos_reg[i]     <= {MID_PULSE_RST, {FRAC_BITS{1'b0}}};
                inc_mag_reg[i] <= '0;
            end
        end
        else
        begin
            strobe_reg <= 1'b0;

            // Take configuration writes
            if (wr_en)
            begin
                case (wr_index)
                    REG_MIN_PULSE: min_reg <= wr_data;
                    REG_MAX_PULSE: max_reg <= wr_data;
                    REG_MID_PULSE: mid_reg <= wr_data;
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        action_reg  <= action;
                        chan_reg    <= channel;
                        chan_ok_reg <= in_ok;
                        pulse_reg   <= pulse;
                        dur_reg     <= duration_ms;
                        pend_reg    <= '0;
                        idx_reg     <= '0;
                        state_reg   <= S_FINISH;
                        case (action)
                            ACT_TICK:
                            begin
                                state_reg <= S_TICK_DIFF;
                            end
                            ACT_SET_NOW:
                            begin
                                if (in_ok)
                                begin
                                    target_reg[in_ch]  <= setnow_pulse;
                                    pos_reg[in_ch]     <= {setnow_pulse, {FRAC_BITS{1'b0}}};
                                    inc_mag_reg[in_ch] <= '0;
                                    inc_neg_reg[in_ch] <= 1'b0;
                                    pend_reg[in_ch]    <= 1'b1;
                                end
                            end
                            ACT_SET_TIMED:
                            begin
                                if (in_ok)
                                begin
                                    idx_reg   <= in_ch;
                                    state_reg <= S_TIMED_DIFF;
                                end
                            end
                            ACT_STOP_ALL:
                            begin
                                for (int i = 0; i < CHANNELS; i++)
                                begin
                                    target_reg[i]  <= pos_reg[i][POS_W-1 -: PULSE_W];
                                    inc_mag_reg[i] <= '0;
                                end
                                inc_neg_reg <= '0;
                            end
                            ACT_RESET_ALL:
                            begin
                                state_reg <= S_TIMED_DIFF;
                            end
                            ACT_QUERY:
                            begin
                                if (in_ok)
                                begin
                                    idx_reg <= in_ch;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                // Measure distance for a ramping channel, skip idle ones
                S_TICK_DIFF:
                begin
                    if (moving[idx_reg])
                    begin
                        mag_reg   <= mag_next;
                        state_reg <= S_TICK_STEP;
                    end
                    else if (last_ch)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end

                // Advance or snap the channel, flag its compare write
                S_TICK_STEP:
                begin
                    if (snap)
                    begin
                        pos_reg[idx_reg]     <= {tgt_rd, {FRAC_BITS{1'b0}}};
                        inc_mag_reg[idx_reg] <= '0;
                        inc_neg_reg[idx_reg] <= 1'b0;
                    end
                    else
                    begin
                        pos_reg[idx_reg] <= pos_step_next;
                    end
                    pend_reg[idx_reg] <= 1'b1;
                    if (last_ch)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_TICK_DIFF;
                    end
                end

                // Set the target; snap on a short duration, else start a ramp
                S_TIMED_DIFF:
                begin
                    target_reg[idx_reg] <= timed_pulse;
                    if (dur_short)
                    begin
                        pos_reg[idx_reg]     <= {timed_pulse, {FRAC_BITS{1'b0}}};
                        inc_mag_reg[idx_reg] <= '0;
                        inc_neg_reg[idx_reg] <= 1'b0;
                        pend_reg[idx_reg]    <= 1'b1;
                        if (action_reg == ACT_RESET_ALL && !last_ch)
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                    else
                    begin
                        mag_reg   <= mag_next;
                        neg_reg   <= diff[POS_W];
                        state_reg <= S_DIV_START;
                    end
                end

                S_DIV_START:
                begin
                    state_reg <= S_DIV_WAIT;
                end

                // Store the increment once the divider finishes
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        inc_mag_reg[idx_reg] <= quo_fix;
                        inc_neg_reg[idx_reg] <= neg_reg;
                        if (action_reg == ACT_RESET_ALL && !last_ch)
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_TIMED_DIFF;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end

                S_FINISH:
                begin
                    if (pend_reg != '0)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_STATUS;
                    end
                end

                // Walk the channels and emit one compare write per flagged one
                S_EMIT:
                begin
                    if (pend_reg[idx_reg])
                    begin
                        strobe_reg        <= 1'b1;
                        out_channel_reg   <= CHAN_W'(idx_reg);
                        out_pulse_reg     <= shown;
                        write_valid_reg   <= 1'b1;
                        done_mask_reg     <= mask_now;
                        all_done_reg      <= ~|moving;
                        last_reg          <= pend_rest == '0;
                        pend_reg[idx_reg] <= 1'b0;
                    end
                    if (pend_rest == '0)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end

                // Single status result
                S_STATUS:
                begin
                    strobe_reg      <= 1'b1;
                    write_valid_reg <= 1'b0;
                    done_mask_reg   <= mask_now;
                    all_done_reg    <= ~|moving;
                    last_reg        <= 1'b1;
                    if (action_reg inside {ACT_SET_NOW, ACT_SET_TIMED, ACT_QUERY})
                    begin
                        out_channel_reg <= chan_reg;
                    end
                    else
                    begin
                        out_channel_reg <= '0;
                    end
                    if (action_reg == ACT_QUERY && chan_ok_reg)
                    begin
                        out_pulse_reg <= shown;
                    end
                    else
                    begin
                        out_pulse_reg <= '0;
                    end
                    state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = state_reg != S_IDLE;
    assign strobe      = strobe_reg;
    assign out_channel = out_channel_reg;
    assign out_pulse   = out_pulse_reg;
    assign write_valid = write_valid_reg;
    assign done_mask   = done_mask_reg;
    assign all_done    = all_done_reg;
    assign last        = last_reg;

    // A result that is not the final one leaves the block busy
    `SPR_ASSERT_NOW(a_more_keeps_busy, strobe && !last, busy)
    // An accepted transaction always starts work
    `SPR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // The final result is never directly followed by another strobe
    `SPR_ASSERT_NEXT(a_last_ends, strobe && last, !strobe)

endmodule
